// File: rtl/mgsa_pkg.sv
// package: types, opcodes and gf(2^8) helpers for the masked share alu
package mgsa_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_SQUARE   = 3'd1,
    OP_MULTIPLY = 3'd2,
    OP_INVERSE  = 3'd3,
    OP_REFRESH  = 3'd4,
    OP_EXPAND   = 3'd5,
    OP_COLLAPSE = 3'd6,
    OP_UNUSED   = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [23:0] a_shares;
    logic [23:0] b_shares;
    logic [7:0]  plain_value;
    logic [63:0] random_low;
    logic [63:0] random_high;
  } in_word_t;

  typedef struct packed {
    logic [23:0] result_shares;
    logic [7:0]  plain_result;
  } out_word_t;

  // gf(2^8) product reduced by x^8+x^4+x^3+x+1
  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] a;
    logic [7:0] p;
    a = x;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    end
    return p;
  endfunction

  // squaring is linear; here it is the field product of x with itself
  function automatic logic [7:0] gf_sq(input logic [7:0] x);
    return gf_mul(x, x);
  endfunction

endpackage

// File: rtl/masked_gf256_share_alu.sv
// top level: pipelined masked gf(2^8) share alu
//
// channel | ports                      | timing
// in      | start, busy, in_word       | word taken when start && !busy
// out     | done, out_word             | done high one cycle per word
//
// one word enters per cycle; busy stays low, so the pipe never stalls.
// each isw product of the inverse chain has its own register stage, with
// squaring, refresh, x^16 and output stages around them.
// reset (rst, synchronous) clears the stage valid bits only.
module masked_gf256_share_alu #(
  parameter int NUM_SHARES = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mgsa_pkg::in_word_t  in_word,
  output logic               done,
  output mgsa_pkg::out_word_t out_word
);
  import mgsa_pkg::*;

  localparam int NS = NUM_SHARES;
  localparam int NP = NS * (NS - 1) / 2;
  localparam int NST = 8;

  typedef logic [NS-1:0][7:0] sh_t;

  // per-stage state
  logic [NST-1:0] vld;
  opcode_t        op   [NST];
  sh_t            a    [NST];
  sh_t            y    [NST];
  sh_t            w    [NST];
  sh_t            z    [NST];
  logic [7:0]     pl   [NST];
  logic [127:0]   rnd  [NST];
  logic [7:0]     plain_q;

  // isw masked product using pair randoms starting at byte base
  function automatic sh_t isw(input sh_t x, input sh_t v, input logic [127:0] r,
                              input int base);
    sh_t o;
    logic [7:0] m [NS][NS];
    int k;
    k = base;
    for (int i = 0; i < NS; i++) begin
      for (int j = i + 1; j < NS; j++) begin
        m[i][j] = r[8*k +: 8];
        m[j][i] = r[8*k +: 8] ^ gf_mul(x[i], v[j]) ^ gf_mul(x[j], v[i]);
        k++;
      end
    end
    for (int i = 0; i < NS; i++) begin
      o[i] = gf_mul(x[i], v[i]);
      for (int j = 0; j < NS; j++)
        if (j != i) o[i] = o[i] ^ m[i][j];
    end
    return o;
  endfunction

  function automatic sh_t remask(input sh_t s, input logic [127:0] r, input int base);
    sh_t o;
    o = s;
    for (int i = 1; i < NS; i++) begin
      o[i] = o[i] ^ r[8*(base+i-1) +: 8];
      o[0] = o[0] ^ r[8*(base+i-1) +: 8];
    end
    return o;
  endfunction

  function automatic sh_t sq_all(input sh_t s);
    sh_t o;
    for (int i = 0; i < NS; i++) o[i] = gf_sq(s[i]);
    return o;
  endfunction

  function automatic sh_t pow16_all(input sh_t s);
    sh_t o;
    for (int i = 0; i < NS; i++) o[i] = gf_sq(gf_sq(gf_sq(gf_sq(s[i]))));
    return o;
  endfunction

  sh_t ain, bin;
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      ain[i] = in_word.a_shares[8*i +: 8];
      bin[i] = in_word.b_shares[8*i +: 8];
    end
  end

  assign busy = 1'b0;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], start};
    end
  end

  // stage 0: capture, square into z, refresh z
  always_ff @(posedge clk) begin
    op[0]  <= opcode_t'(in_word.opcode);
    a[0]   <= ain;
    y[0]   <= bin;
    pl[0]  <= in_word.plain_value;
    rnd[0] <= {in_word.random_high, in_word.random_low};
    z[0]   <= remask(sq_all(ain), {in_word.random_high, in_word.random_low}, 0);
    w[0]   <= '0;
  end

  // stage 1: single ops done here; inverse gets x^3
  always_ff @(posedge clk) begin
    op[1] <= op[0]; a[1] <= a[0]; pl[1] <= pl[0]; rnd[1] <= rnd[0]; z[1] <= z[0];
    w[1] <= w[0];
    case (op[0])
      OP_ADD:      y[1] <= a[0] ^ y[0];
      OP_SQUARE:   y[1] <= sq_all(a[0]);
      OP_MULTIPLY: y[1] <= isw(a[0], y[0], rnd[0], 0);
      OP_INVERSE:  y[1] <= isw(z[0], a[0], rnd[0], NS - 1);
      OP_REFRESH:  y[1] <= remask(a[0], rnd[0], 0);
      default:     y[1] <= '0;
    endcase
  end

  // stage 2: w = refresh(y^4)
  always_ff @(posedge clk) begin
    op[2] <= op[1]; a[2] <= a[1]; pl[2] <= pl[1]; rnd[2] <= rnd[1]; z[2] <= z[1];
    y[2] <= y[1];
    w[2] <= remask(sq_all(sq_all(y[1])), rnd[1], NS - 1 + NP);
  end

  // stage 3: x^15
  always_ff @(posedge clk) begin
    op[3] <= op[2]; a[3] <= a[2]; pl[3] <= pl[2]; rnd[3] <= rnd[2]; z[3] <= z[2];
    w[3] <= w[2];
    y[3] <= (op[2] == OP_INVERSE) ? isw(y[2], w[2], rnd[2], 2*(NS-1) + NP) : y[2];
  end

  // stage 4: x^240
  always_ff @(posedge clk) begin
    op[4] <= op[3]; a[4] <= a[3]; pl[4] <= pl[3]; rnd[4] <= rnd[3]; z[4] <= z[3];
    w[4] <= w[3];
    y[4] <= (op[3] == OP_INVERSE) ? pow16_all(y[3]) : y[3];
  end

  // stage 5: x^252
  always_ff @(posedge clk) begin
    op[5] <= op[4]; a[5] <= a[4]; pl[5] <= pl[4]; rnd[5] <= rnd[4]; z[5] <= z[4];
    w[5] <= w[4];
    y[5] <= (op[4] == OP_INVERSE) ? isw(y[4], w[4], rnd[4], 2*(NS-1) + 2*NP) : y[4];
  end

  // stage 6: x^254
  always_ff @(posedge clk) begin
    op[6] <= op[5]; a[6] <= a[5]; pl[6] <= pl[5]; rnd[6] <= rnd[5]; z[6] <= z[5];
    w[6] <= w[5];
    y[6] <= (op[5] == OP_INVERSE) ? isw(y[5], z[5], rnd[5], 2*(NS-1) + 3*NP) : y[5];
  end

  // stage 7: expand and collapse, output word
  sh_t        exp_sh;
  logic [7:0] col;
  always_comb begin
    exp_sh = '0;
    exp_sh[NS-1] = pl[6];
    for (int i = 0; i < NS - 1; i++) begin
      exp_sh[i] = rnd[6][8*i +: 8];
      exp_sh[NS-1] = exp_sh[NS-1] ^ rnd[6][8*i +: 8];
    end
    col = 8'h00;
    for (int i = 0; i < NS; i++) col = col ^ a[6][i];
  end

  always_ff @(posedge clk) begin
    op[7] <= op[6];
    case (op[6]) inside
      OP_EXPAND: y[7] <= exp_sh;
      OP_COLLAPSE, OP_UNUSED: y[7] <= '0;
      default: y[7] <= y[6];
    endcase
    plain_q <= (op[6] == OP_COLLAPSE) ? col : 8'h00;
  end

  always_comb begin
    out_word = '0;
    out_word.result_shares[8*NS-1:0] = y[7];
    out_word.plain_result = plain_q;
  end
  assign done = vld[NST-1];

  // checks
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##8 done) else $error("word lost in pipe");
  a_noinv: assert property (@(posedge clk) disable iff (rst)
    done |-> (vld[NST-1] == 1'b1)) else $error("done without valid");
  a_col: assert property (@(posedge clk) disable iff (rst)
    (done && op[7] != OP_COLLAPSE) |-> out_word.plain_result == 8'h00)
    else $error("plain result leaked");
endmodule

// File: sim/tb_masked_gf256_share_alu.sv
// testbench for the masked gf(2^8) share alu: directed and random words checked against a predictor
`timescale 1ns / 100ps

module tb_masked_gf256_share_alu;
  import mgsa_pkg::*;

  localparam int NSH = 3;
  localparam int LATENCY = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  in_word_t in_word = '0;
  out_word_t out_word;

  out_word_t expected_words[$];
  int errors = 0;
  bit gaps_on = 1'b1;

  masked_gf256_share_alu #(.NUM_SHARES(NSH)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .done(done), .out_word(out_word)
  );

  always #6 clk = ~clk;

  // field product modulo the aes polynomial
  function automatic logic [7:0] fmul(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] a;
    logic [7:0] p;
    a = {1'b0, x};
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (y[i]) p ^= a[7:0];
      a = a << 1;
      if (a[8]) a ^= 9'h11B;
    end
    return p;
  endfunction

  typedef logic [7:0] shv_t [NSH];

  // random byte pool, taken in order of use
  logic [127:0] pool;
  int pool_pos;

  function automatic logic [7:0] take_byte();
    logic [7:0] b;
    b = pool[8 * (pool_pos % 16) +: 8];
    pool_pos++;
    return b;
  endfunction

  function automatic shv_t remask(input shv_t s);
    logic [7:0] t;
    for (int i = 1; i < NSH; i++) begin
      t = take_byte();
      s[i] ^= t;
      s[0] ^= t;
    end
    return s;
  endfunction

  function automatic shv_t isw(input shv_t a, input shv_t b);
    logic [7:0] m [NSH][NSH];
    shv_t r;
    for (int i = 0; i < NSH; i++)
      for (int j = i + 1; j < NSH; j++) begin
        m[i][j] = take_byte();
        m[j][i] = m[i][j] ^ fmul(a[i], b[j]) ^ fmul(a[j], b[i]);
      end
    for (int i = 0; i < NSH; i++) begin
      r[i] = fmul(a[i], b[i]);
      for (int j = 0; j < NSH; j++)
        if (j != i) r[i] ^= m[i][j];
    end
    return r;
  endfunction

  function automatic logic [7:0] pow2k(input logic [7:0] x, input int k);
    for (int i = 0; i < k; i++) x = fmul(x, x);
    return x;
  endfunction

  function automatic out_word_t predict_alu(input in_word_t w);
    shv_t a, b, r, z, y, v;
    out_word_t o;
    logic [7:0] acc;
    pool = {w.random_high, w.random_low};
    pool_pos = 0;
    o = '0;
    for (int i = 0; i < NSH; i++) begin
      a[i] = w.a_shares[8*i +: 8];
      b[i] = w.b_shares[8*i +: 8];
      r[i] = 8'h00;
    end
    case (opcode_t'(w.opcode))
      OP_ADD:      for (int i = 0; i < NSH; i++) r[i] = a[i] ^ b[i];
      OP_SQUARE:   for (int i = 0; i < NSH; i++) r[i] = fmul(a[i], a[i]);
      OP_MULTIPLY: r = isw(a, b);
      OP_INVERSE: begin
        for (int i = 0; i < NSH; i++) z[i] = fmul(a[i], a[i]);
        z = remask(z);
        y = isw(z, a);
        for (int i = 0; i < NSH; i++) v[i] = pow2k(y[i], 2);
        v = remask(v);
        y = isw(y, v);
        for (int i = 0; i < NSH; i++) y[i] = pow2k(y[i], 4);
        y = isw(y, v);
        r = isw(y, z);
      end
      OP_REFRESH:  r = remask(a);
      OP_EXPAND: begin
        acc = w.plain_value;
        for (int i = 0; i < NSH - 1; i++) begin
          r[i] = take_byte();
          acc ^= r[i];
        end
        r[NSH-1] = acc;
      end
      OP_COLLAPSE: begin
        acc = 8'h00;
        for (int i = 0; i < NSH; i++) acc ^= a[i];
        o.plain_result = acc;
      end
      default: ;
    endcase
    if (opcode_t'(w.opcode) inside {OP_ADD, OP_SQUARE, OP_MULTIPLY, OP_INVERSE,
                                     OP_REFRESH, OP_EXPAND})
      for (int i = 0; i < NSH; i++) o.result_shares[8*i +: 8] = r[i];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_word, 32'h0);
      end else begin
        want = expected_words.pop_front();
        if (out_word.result_shares !== want.result_shares)
          report_mismatch("result_shares", {8'h00, out_word.result_shares},
                          {8'h00, want.result_shares});
        if (out_word.plain_result !== want.plain_result)
          report_mismatch("plain_result", {24'h000000, out_word.plain_result},
                          {24'h000000, want.plain_result});
      end
    end
  end

  // random fill for a whole input word
  function automatic in_word_t rand_bits();
    logic [191:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return v[$bits(in_word_t)-1:0];
  endfunction

  // send one word, with random idle cycles ahead of it while gaps_on is set
  task automatic send_word(input in_word_t w);
    while (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      in_word <= rand_bits();
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(predict_alu(w));
  endtask

  function automatic in_word_t rand_word(input logic [2:0] op);
    in_word_t w;
    w = rand_bits();
    w.opcode = op;
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    for (int op = 0; op < 8; op++) begin
      w = '0; w.opcode = op[2:0];
      send_word(w);
      w = '1; w.opcode = op[2:0];
      send_word(w);
    end
    // inverse of a sharing of zero
    w = rand_word(OP_INVERSE);
    w.a_shares[23:16] = w.a_shares[7:0] ^ w.a_shares[15:8];
    send_word(w);
    // inverse of one, plain extremes in expand
    w = rand_word(OP_INVERSE); w.a_shares = 24'h000001; send_word(w);
    w = rand_word(OP_EXPAND); w.plain_value = 8'hFF; send_word(w);
    w = rand_word(OP_EXPAND); w.plain_value = 8'h00; send_word(w);
    w = rand_word(OP_MULTIPLY); w.a_shares = 24'hFFFFFF; w.b_shares = 24'hFFFFFF;
    send_word(w);
    w = rand_word(OP_COLLAPSE); send_word(w);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      gaps_on = !(n >= count / 3 && n < count / 2);
      send_word(rand_word(3'($urandom_range(7))));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1850);
    test_drain();
    if (errors == 0)
      $display("tb_masked_gf256_share_alu OK");
    else
      $display("tb_masked_gf256_share_alu NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_masked_gf256_share_alu NOT OK");
    $finish;
  end

endmodule
